// File: design/vne_pkg.sv
package vne_pkg;

  // Default element width; the top level takes it as a parameter.
  localparam int DEFAULT_SAMPLE_BITS = 24;

  // Running sum of squares (unsigned Q32.32) and the norm (unsigned Q16.16).
  localparam int SUM_BITS  = 64;
  localparam int NORM_BITS = 32;

  // Finished sums waiting for the square root unit.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // The square root produces one result bit per step.
  localparam int ROOT_STEPS     = SUM_BITS / 2;
  localparam int ROOT_CNT_BITS  = $clog2(ROOT_STEPS);
  localparam logic [SUM_BITS-1:0] ROOT_START_BIT = SUM_BITS'(1) << (SUM_BITS - 2);

  // One finished vector: its clamped sum of squares and the saturation flag.
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic                sat;
  } vne_total_t;

  // Occupancy and head of the queue, as seen by the back end.
  typedef struct packed {
    logic       empty;
    vne_total_t head;
  } vne_queue_status_t;

  typedef enum logic [0:0] {
    BACK_IDLE,
    BACK_CALC
  } back_state_t;

endpackage

// File: design/vector_euclidean_norm.sv
// Streaming Euclidean norm of a signed fixed-point vector.
// Input channel s_axis: one vector element per transfer, tdata holds the signed
// sample (Q8.16 at the default width) and tlast marks the final element.
// Output channel m_axis: one transfer per vector, tdata holds the norm as
// unsigned Q16.16 and tuser the flag that the sum of squares saturated.
// The front end takes one element per cycle while s_axis_tready is high: it
// registers the magnitude, then its square, then adds it to a 64-bit sum that
// clamps at its maximum. A finished sum goes into a four-entry queue in front
// of the square root unit. The square root loads a queued sum, then resolves
// one result bit per cycle in 32 steps; the final step waits for the output.
// Sustained input rate is one element per cycle while vectors are long enough
// for the square root to keep up; shorter vectors are limited by the square
// root, and s_axis_tready drops once the queue has no slot left for the
// elements in flight.
// When m_axis_tready is low the result waits in the output register; the next
// square root then holds on its final step and the queue fills behind it.
// Synchronous reset clears the running sum, the flag, the queue and
// m_axis_tvalid, and s_axis_tready stays low while it is asserted.
module vector_euclidean_norm
  import vne_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample [SAMPLE_BITS-1:0], zero padding up to a whole byte
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // norm [31:0]
  output logic [NORM_BITS-1:0]                 m_axis_tdata,
  // saturated [0]
  output logic [0:0]                           m_axis_tuser
);

  logic                 q_push;
  vne_total_t           q_push_data;
  logic                 q_pop;
  logic [QCNT_BITS-1:0] q_count;
  vne_queue_status_t    q_status;
  logic                 out_sat;

  vne_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last   (s_axis_tlast),
    .q_count   (q_count),
    .push      (q_push),
    .push_data (q_push_data)
  );

  vne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .count     (q_count),
    .status    (q_status)
  );

  vne_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_norm  (m_axis_tdata),
    .out_sat   (out_sat)
  );

  assign m_axis_tuser[0] = out_sat;

  // A finished vector always finds a free queue slot.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count != QCNT_BITS'(QUEUE_DEPTH)) || q_pop)
    else $error("queue written while full");

  // The square root unit only starts on a queued sum.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");

  // A saturated sum stays at its maximum, whose root is all ones.
  a_sat_norm: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == {NORM_BITS{1'b1}}))
    else $error("saturated result with a norm below maximum");

  // A new result follows a square root run; the property as written is always true, as empty means a zero count.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!q_status.empty || q_count == '0))
    else $error("result appeared without a square root run");

endmodule

// File: design/vne_front.sv
module vne_front
  import vne_pkg::*;
#(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last,
  input  logic [QCNT_BITS-1:0]   q_count,
  output logic                   push,
  output vne_total_t             push_data
);

  localparam int SQ_BITS = 2 * SAMPLE_BITS;

  logic                   v1;
  logic                   last1;
  logic [SAMPLE_BITS-1:0] mag1;
  logic                   v2;
  logic                   last2;
  logic [SQ_BITS-1:0]     sq2;
  logic [SUM_BITS-1:0]    sum;
  logic                   flag;

  logic [SAMPLE_BITS-1:0] mag_next;
  logic [SQ_BITS-1:0]     sq_next;
  logic [SUM_BITS:0]      total_ext;
  logic [SUM_BITS-1:0]    total_sat;
  logic                   flag_next;
  logic [QCNT_BITS:0]     reserved;

  // Every item in flight may end a vector, so each one holds a queue slot.
  // Nothing is taken while reset is asserted.
  assign reserved = {1'b0, q_count} + (QCNT_BITS + 1)'(v1) + (QCNT_BITS + 1)'(v2);
  assign in_ready = !rst && (reserved < (QCNT_BITS + 1)'(QUEUE_DEPTH));

  // Magnitude of a two's complement sample; the most negative one fits unsigned.
  assign mag_next = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;

  assign sq_next = mag1 * mag1;

  // Add with a carry bit and clamp to all ones on overflow.
  assign total_ext = {1'b0, sum} + (SUM_BITS + 1)'(sq2);
  assign total_sat = total_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : total_ext[SUM_BITS-1:0];
  assign flag_next = flag | total_ext[SUM_BITS] | (&total_ext[SUM_BITS-1:0]);

  assign push          = v2 & last2;
  assign push_data.sum = total_sat;
  assign push_data.sat = flag_next;

  // Valid bits of the magnitude and square stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid & in_ready;
      v2 <= v1;
    end
  end

  // Payload of the magnitude and square stages.
  always_ff @(posedge clk) begin
    mag1  <= mag_next;
    last1 <= in_last;
    sq2   <= sq_next;
    last2 <= last1;
  end

  // Running sum; a vector's end hands the total to the queue and clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      flag <= 1'b0;
    end else if (v2) begin
      if (last2) begin
        sum  <= '0;
        flag <= 1'b0;
      end else begin
        sum  <= total_sat;
        flag <= flag_next;
      end
    end
  end

endmodule

// File: design/vne_queue.sv
module vne_queue
  import vne_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vne_total_t         push_data,
  input  logic               pop,
  output logic [QCNT_BITS-1:0] count,
  output vne_queue_status_t  status
);

  vne_total_t           entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;

  assign status.empty = (count == '0);
  assign status.head  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: design/vne_back.sv
module vne_back
  import vne_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  vne_queue_status_t    q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NORM_BITS-1:0] out_norm,
  output logic                 out_sat
);

  back_state_t              state;
  back_state_t              state_next;
  logic [SUM_BITS-1:0]      op;
  logic [SUM_BITS-1:0]      res;
  logic [SUM_BITS-1:0]      bit_mask;
  logic [ROOT_CNT_BITS-1:0] cnt;
  logic                     sat_hold;

  logic [SUM_BITS-1:0]      trial;
  logic                     take;
  logic [SUM_BITS-1:0]      res_step;
  logic [SUM_BITS-1:0]      op_step;
  logic                     start;
  logic                     iterate;
  logic                     finish;

  // One step of the bitwise square root.
  assign trial    = res + bit_mask;
  assign take     = op >= trial;
  assign res_step = take ? ((res >> 1) + bit_mask) : (res >> 1);
  assign op_step  = take ? (op - trial) : op;

  // Next state and step control.
  always_comb begin
    state_next = state;
    start      = 1'b0;
    iterate    = 1'b0;
    finish     = 1'b0;
    unique case (state)
      BACK_IDLE: begin
        if (!q_status.empty) begin
          start      = 1'b1;
          state_next = BACK_CALC;
        end
      end
      BACK_CALC: begin
        if (cnt != '0) begin
          iterate = 1'b1;
        end else if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  assign pop = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Square root datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      op       <= q_status.head.sum;
      res      <= '0;
      bit_mask <= ROOT_START_BIT;
      cnt      <= ROOT_CNT_BITS'(ROOT_STEPS - 1);
      sat_hold <= q_status.head.sat;
    end else if (iterate) begin
      op       <= op_step;
      res      <= res_step;
      bit_mask <= bit_mask >> 2;
      cnt      <= cnt - ROOT_CNT_BITS'(1);
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_norm <= res_step[NORM_BITS-1:0];
      out_sat  <= sat_hold;
    end
  end

endmodule

// File: test/vector_euclidean_norm_test.sv
`timescale 1ns / 100ps

module vector_euclidean_norm_test;
  import vne_pkg::*;

  localparam int SB = DEFAULT_SAMPLE_BITS;
  localparam int TDATA_W = ((SB + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PRINT_CAP = 50;
  localparam int ROW_COUNT = 16;

  // One expected norm transfer.
  typedef struct {
    logic [NORM_BITS-1:0] norm;
    logic                 sat;
  } norm_result_t;

  // One row of the directed table; last applies to the final repetition only.
  typedef struct {
    logic [SB-1:0]        sample;
    logic                 last;
    int                   reps;
    logic                 fixed_exp;
    logic [NORM_BITS-1:0] norm;
    logic                 sat;
  } vec_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // sample [23:0]
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // norm [31:0]
  logic [NORM_BITS-1:0] m_axis_tdata;
  // saturated [0]
  logic [0:0]           m_axis_tuser;

  // Predictor state: running sum of squares and its sticky saturation flag.
  logic [SUM_BITS-1:0]  sq_sum = '0;
  logic                 sum_clamped = 1'b0;

  norm_result_t         norm_q[$];
  norm_result_t         got_exp;
  vec_row_t             vector_rows[ROW_COUNT];
  int                   errors = 0;
  int                   cycles = 0;
  logic                 idle_en = 1'b1;

  vector_euclidean_norm #(
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Count and print a mismatch; printing stops after a cap.
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  // Floor square root, built up one root bit at a time from the top.
  function automatic logic [NORM_BITS-1:0] floor_sqrt(input logic [SUM_BITS-1:0] value);
    logic [SUM_BITS-1:0] root;
    logic [SUM_BITS-1:0] trial;
    root = '0;
    for (int i = NORM_BITS - 1; i >= 0; i--) begin
      trial = root | (SUM_BITS'(1) << i);
      if (trial * trial <= value) begin
        root = trial;
      end
    end
    return root[NORM_BITS-1:0];
  endfunction

  // Fold one accepted element into the sum; returns 1 with the norm on the last one.
  function automatic logic accumulate_square(input logic [SB-1:0] element, input logic lst,
                                             output norm_result_t res);
    logic [SUM_BITS-1:0] mag;
    logic [SUM_BITS-1:0] sq;
    logic [SUM_BITS:0]   total;
    mag = element[SB-1] ? (SUM_BITS'(1) << SB) - SUM_BITS'(element) : SUM_BITS'(element);
    sq = mag * mag;
    total = {1'b0, sq_sum} + {1'b0, sq};
    if (total[SUM_BITS]) begin
      sq_sum = '1;
      sum_clamped = 1'b1;
    end else begin
      sq_sum = total[SUM_BITS-1:0];
      if (sq_sum == '1) begin
        sum_clamped = 1'b1;
      end
    end
    res.norm = '0;
    res.sat = 1'b0;
    if (!lst) begin
      return 1'b0;
    end
    res.norm = floor_sqrt(sq_sum);
    res.sat = sum_clamped;
    sq_sum = '0;
    sum_clamped = 1'b0;
    return 1'b1;
  endfunction

  // Present one element at the falling edge and hold it until the transfer completes.
  task automatic send_element(input logic [SB-1:0] element, input logic lst,
                              input logic fixed_exp, input logic [NORM_BITS-1:0] exp_norm,
                              input logic exp_sat);
    norm_result_t res;
    while (idle_en && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = TDATA_W'(element);
    s_axis_tlast = lst;
    do @(posedge clk); while (!s_axis_tready);
    if (accumulate_square(element, lst, res)) begin
      if (fixed_exp) begin
        res.norm = exp_norm;
        res.sat = exp_sat;
      end
      norm_q.push_back(res);
    end
    @(negedge clk);
  endtask

  // Receiver: stall at random, except while idling is switched off.
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      m_axis_tready = idle_en ? ($urandom_range(0, 99) >= 13) : 1'b1;
    end
  end

  // Compare each result transfer with the oldest expected norm.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (norm_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result norm=%0d sat=%0d",
                                  m_axis_tdata, m_axis_tuser[0]));
      end else begin
        got_exp = norm_q.pop_front();
        if (m_axis_tdata !== got_exp.norm) begin
          report_mismatch($sformatf("norm got %0d expected %0d", m_axis_tdata, got_exp.norm));
        end
        if (m_axis_tuser[0] !== got_exp.sat) begin
          report_mismatch($sformatf("saturated got %0d expected %0d",
                                    m_axis_tuser[0], got_exp.sat));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int                   sent;
    int                   len;
    int                   pick;
    int                   kind;
    logic [SB-1:0]        element;
    logic [SB-1:0]        mag_small;

    // Directed table: reset state, unit values, extremes, a 3-4-5 vector, and a
    // vector longer than the root latency.
    vector_rows = '{
      '{24'h000000, 1'b1, 1, 1'b1, 32'd0, 1'b0},
      '{24'h010000, 1'b1, 1, 1'b1, 32'd65536, 1'b0},
      '{24'hFF0000, 1'b1, 1, 1'b1, 32'd65536, 1'b0},
      '{24'h7FFFFF, 1'b1, 1, 1'b1, 32'd8388607, 1'b0},
      '{24'h800000, 1'b1, 1, 1'b1, 32'd8388608, 1'b0},
      '{24'h000001, 1'b1, 1, 1'b1, 32'd1, 1'b0},
      '{24'hFFFFFF, 1'b1, 1, 1'b1, 32'd1, 1'b0},
      '{24'h030000, 1'b0, 1, 1'b0, 32'd0, 1'b0},
      '{24'hFC0000, 1'b1, 1, 1'b1, 32'd327680, 1'b0},
      '{24'h010000, 1'b1, 4, 1'b1, 32'd131072, 1'b0},
      '{24'h123456, 1'b0, 1, 1'b0, 32'd0, 1'b0},
      '{24'hABCDEF, 1'b0, 1, 1'b0, 32'd0, 1'b0},
      '{24'h555555, 1'b0, 1, 1'b0, 32'd0, 1'b0},
      '{24'hAAAAAA, 1'b1, 1, 1'b0, 32'd0, 1'b0},
      '{24'h7FFFFF, 1'b1, 40, 1'b0, 32'd0, 1'b0},
      '{24'h020000, 1'b1, 1, 1'b1, 32'd131072, 1'b0}
    };

    // Reset is held, then released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part.
    foreach (vector_rows[r]) begin
      for (int k = 0; k < vector_rows[r].reps; k++) begin
        send_element(vector_rows[r].sample,
                     vector_rows[r].last && (k == vector_rows[r].reps - 1),
                     vector_rows[r].fixed_exp, vector_rows[r].norm, vector_rows[r].sat);
      end
    end
    idle_en = 1'b1;

    // Random vectors of mixed length and content; one stretch runs with no idling.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = 1;
      end else if (pick < 85) begin
        len = $urandom_range(2, 40);
      end else begin
        len = $urandom_range(41, 120);
      end
      idle_en = !(sent >= 700 && sent < 1000);
      for (int k = 0; k < len; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          element = SB'($urandom);
        end else if (kind < 8) begin
          mag_small = SB'($urandom_range(0, 1023));
          element = $urandom_range(0, 1) ? -mag_small : mag_small;
        end else begin
          case ($urandom_range(0, 3))
            0: element = 24'h7FFFFF;
            1: element = 24'h800000;
            2: element = 24'h000000;
            default: element = 24'hFFFFFF;
          endcase
        end
        send_element(element, k == len - 1, 1'b0, '0, 1'b0);
        sent++;
      end
    end
    idle_en = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;

    // Drain: wait for every expected norm, then a little longer for strays.
    while (norm_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (norm_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", norm_q.size()));
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
